>>> design/ipu_pkg.sv
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared types, constants and pixel functions of the integer pixel upscaler.
// ----------------------------------------------------------------------------
package ipu_pkg;

  localparam int unsigned SCREEN_W_DEF   = 640;
  localparam int unsigned SCREEN_H_DEF   = 480;

  localparam int unsigned W_PIX          = 16;
  localparam int unsigned W_SX           = 10;
  localparam int unsigned W_SY           = 9;
  localparam int unsigned W_LOOK         = 2;
  localparam int unsigned W_FDRAW        = 3;
  localparam int unsigned W_BLK          = 2;

  localparam int unsigned APB_AW         = 4;
  localparam int unsigned APB_DW         = 32;

  localparam logic [W_SX-1:0]   RST_SRC_WIDTH  = W_SX'(160);
  localparam logic [W_SY-1:0]   RST_SRC_HEIGHT = W_SY'(144);
  localparam logic [W_LOOK-1:0] RST_LOOK_MODE  = W_LOOK'(0);

  localparam logic [W_LOOK-1:0] LOOK_LCD = W_LOOK'(1);
  localparam logic [W_LOOK-1:0] LOOK_DMG = W_LOOK'(2);

  localparam logic [W_PIX-1:0] MASK_R = 16'hf800;
  localparam logic [W_PIX-1:0] MASK_G = 16'h07e0;
  localparam logic [W_PIX-1:0] MASK_B = 16'h001f;
  localparam logic [W_PIX-1:0] PIX_BLACK = 16'h0000;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_LOOK_MODE  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_LCD   = 2'd1,
    KIND_DMG   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [W_PIX-1:0] pixel_in;
    logic [W_SX-1:0]  src_x;
    logic [W_SY-1:0]  src_y;
  } in_t;

  typedef struct packed {
    logic [W_PIX-1:0] pixel_out;
    logic [W_SX-1:0]  dst_x;
    logic [W_SY-1:0]  dst_y;
    logic             block_last;
  } out_t;

  typedef struct packed {
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
  } apb_req_t;

  typedef struct packed {
    logic [W_FDRAW-1:0] fdraw;
    logic [W_LOOK-1:0]  look;
    logic [W_SX-1:0]    off_x;
    logic [W_SY-1:0]    off_y;
  } cfg_t;

  typedef struct packed {
    logic [W_PIX-1:0]   pix;
    logic [W_PIX-1:0]   lb;
    logic [W_PIX-1:0]   lc;
    logic [W_SX-1:0]    bx;
    logic [W_SY-1:0]    by;
    logic [W_FDRAW-1:0] fdraw;
    kind_e              kind;
  } ent_t;

  // Division by five of a value below 512 by reciprocal multiplication.
  function automatic logic [6:0] div5(input logic [8:0] x);
    logic [16:0] m;
    m = 17'(x) * 17'd205;
    return m[16:10];
  endfunction

  // Per-channel blend toward white: (wp * p + ww * white) / 5.
  function automatic logic [W_PIX-1:0] blend_white(input logic [W_PIX-1:0] p,
                                                   input logic [1:0] wp,
                                                   input logic [1:0] ww);
    logic [8:0] sr;
    logic [8:0] sg;
    logic [8:0] sb;
    logic [6:0] qr;
    logic [6:0] qg;
    logic [6:0] qb;
    sr = 9'(wp) * 9'(p[15:11]) + 9'(ww) * 9'd31;
    sg = 9'(wp) * 9'(p[10:5]) + 9'(ww) * 9'd63;
    sb = 9'(wp) * 9'(p[4:0]) + 9'(ww) * 9'd31;
    qr = div5(sr);
    qg = div5(sg);
    qb = div5(sb);
    return {qr[4:0], qg[5:0], qb[4:0]};
  endfunction

endpackage

>>> design/integer_pixel_upscaler.sv
// ----------------------------------------------------------------------------
// integer_pixel_upscaler
// Integer nearest-neighbor upscaler of RGB565 pixels onto a fixed screen.
// An accepted item is queued, and the emitter registers its beats onto the output.
// Each item yields f*f beats (1, 4, 9 or 16), one per cycle, set by the emitter.
// After reset and after each register write the block is busy while the serial
// divider derives the QW-bit factor, QW = clog2(max(SCREEN_W,SCREEN_H)+1).
// The receiver cannot stall; reset clears the queue and restores the registers.
// ----------------------------------------------------------------------------
module integer_pixel_upscaler #(
  parameter int unsigned SCREEN_W = ipu_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = ipu_pkg::SCREEN_H_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ipu_pkg::in_t               pix_i,
  output logic                       res_valid_o,
  output ipu_pkg::out_t              res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ipu_pkg::APB_AW-1:0] paddr,
  input  logic [ipu_pkg::APB_DW-1:0] pwdata,
  output logic [ipu_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import ipu_pkg::*;

  apb_req_t apb;
  cfg_t     cfg;
  ent_t     ent, head;
  logic     cfg_busy, q_push, q_pop, q_empty, q_full;

  assign apb.psel    = psel;
  assign apb.penable = penable;
  assign apb.pwrite  = pwrite;
  assign apb.paddr   = paddr;
  assign apb.pwdata  = pwdata;
  assign pready      = 1'b1;

  ipu_cfg #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apb_i    (apb),
    .prdata_o (prdata),
    .cfg_o    (cfg),
    .busy_o   (cfg_busy)
  );

  ipu_front u_front (
    .cfg_i (cfg),
    .pix_i (pix_i),
    .ent_o (ent)
  );

  assign busy   = cfg_busy | q_full;
  assign q_push = start & !busy;

  ipu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (ent),
    .pop_i   (q_pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ipu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("Item pushed into a full queue.");

  a_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_empty) |=> ##1 res_valid_o)
    else $error("No result beat two cycles after accepting into an empty queue.");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> busy)
    else $error("Block not busy after a register write.");

endmodule

>>> design/ipu_cfg.sv
// ----------------------------------------------------------------------------
// ipu_cfg
// Register file and derivation of scale factor and centering offsets.
// ----------------------------------------------------------------------------
module ipu_cfg #(
  parameter int unsigned SCREEN_W = ipu_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = ipu_pkg::SCREEN_H_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ipu_pkg::apb_req_t          apb_i,
  output logic [ipu_pkg::APB_DW-1:0] prdata_o,
  output ipu_pkg::cfg_t              cfg_o,
  output logic                       busy_o
);
  import ipu_pkg::*;

  localparam int unsigned SMAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
  localparam int unsigned QW   = $clog2(SMAX + 1);
  localparam int unsigned CW   = $clog2(QW);
  localparam int unsigned PXW  = W_SX + QW;
  localparam int unsigned PYW  = W_SY + QW;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MIN  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_OFS  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [W_SX-1:0]   src_width_q;
  logic [W_SY-1:0]   src_height_q;
  logic [W_LOOK-1:0] look_q;

  logic [CW-1:0]    cnt_q;
  logic [QW-1:0]    dvx_q, dvy_q;
  logic [QW-1:0]    qx_q, qy_q;
  logic [W_SX-1:0]  remx_q;
  logic [W_SY-1:0]  remy_q;
  logic [QW-1:0]    fac_q;
  logic [PXW-1:0]   prodx_q;
  logic [PYW-1:0]   prody_q;
  logic [W_SX-1:0]  offx_q;
  logic [W_SY-1:0]  offy_q;
  logic [W_FDRAW-1:0] fdraw_q;

  logic             wr;
  reg_idx_e         widx;
  logic [W_SX-1:0]  w_eff;
  logic [W_SY-1:0]  h_eff;
  logic [W_SX:0]    tx;
  logic [W_SY:0]    ty;
  logic             gex, gey;
  logic [PXW-1:0]   diffx;
  logic [PYW-1:0]   diffy;

  assign wr    = apb_i.psel & apb_i.penable & apb_i.pwrite;
  assign widx  = reg_idx_e'(apb_i.paddr[3:2]);
  assign w_eff = (src_width_q == '0) ? W_SX'(1) : src_width_q;
  assign h_eff = (src_height_q == '0) ? W_SY'(1) : src_height_q;

  assign tx  = {remx_q, dvx_q[QW-1]};
  assign ty  = {remy_q, dvy_q[QW-1]};
  assign gex = (tx >= {1'b0, w_eff});
  assign gey = (ty >= {1'b0, h_eff});

  assign diffx = PXW'(SCREEN_W) - prodx_q;
  assign diffy = PYW'(SCREEN_H) - prody_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  state_d = (cnt_q == CW'(QW - 1)) ? ST_MIN : ST_DIV;
      ST_MIN:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_OFS;
      ST_OFS:  state_d = ST_IDLE;
      default: state_d = ST_LOAD;
    endcase
    if (wr) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      look_q       <= RST_LOOK_MODE;
    end else begin
      state_q <= state_d;
      if (wr) begin
        case (widx)
          REG_SRC_WIDTH:  src_width_q  <= apb_i.pwdata[W_SX-1:0];
          REG_SRC_HEIGHT: src_height_q <= apb_i.pwdata[W_SY-1:0];
          REG_LOOK_MODE:  look_q       <= apb_i.pwdata[W_LOOK-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        dvx_q  <= QW'(SCREEN_W);
        dvy_q  <= QW'(SCREEN_H);
        qx_q   <= '0;
        qy_q   <= '0;
        remx_q <= '0;
        remy_q <= '0;
        cnt_q  <= '0;
      end
      ST_DIV: begin
        dvx_q  <= {dvx_q[QW-2:0], 1'b0};
        dvy_q  <= {dvy_q[QW-2:0], 1'b0};
        qx_q   <= {qx_q[QW-2:0], gex};
        qy_q   <= {qy_q[QW-2:0], gey};
        remx_q <= W_SX'(gex ? (tx - {1'b0, w_eff}) : tx);
        remy_q <= W_SY'(gey ? (ty - {1'b0, h_eff}) : ty);
        cnt_q  <= cnt_q + CW'(1);
      end
      ST_MIN: begin
        fac_q <= (qx_q < qy_q) ? qx_q : qy_q;
      end
      ST_MUL: begin
        prodx_q <= {{QW{1'b0}}, w_eff} * {{W_SX{1'b0}}, fac_q};
        prody_q <= {{QW{1'b0}}, h_eff} * {{W_SY{1'b0}}, fac_q};
      end
      ST_OFS: begin
        offx_q  <= W_SX'(diffx >> 1);
        offy_q  <= W_SY'(diffy >> 1);
        fdraw_q <= (fac_q >= QW'(2) && fac_q <= QW'(4)) ? W_FDRAW'(fac_q)
                                                         : W_FDRAW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (reg_idx_e'(apb_i.paddr[3:2]))
      REG_SRC_WIDTH:  prdata_o = APB_DW'(src_width_q);
      REG_SRC_HEIGHT: prdata_o = APB_DW'(src_height_q);
      REG_LOOK_MODE:  prdata_o = APB_DW'(look_q);
      default:        prdata_o = '0;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_o.fdraw = fdraw_q;
  assign cfg_o.look  = look_q;
  assign cfg_o.off_x = offx_q;
  assign cfg_o.off_y = offy_q;

endmodule

>>> design/ipu_front.sv
// ----------------------------------------------------------------------------
// ipu_front
// Classifies an incoming pixel and prepares its block origin and blends.
// ----------------------------------------------------------------------------
module ipu_front (
  input  ipu_pkg::cfg_t cfg_i,
  input  ipu_pkg::in_t  pix_i,
  output ipu_pkg::ent_t ent_o
);
  import ipu_pkg::*;

  logic [W_SX+W_FDRAW-1:0] mx;
  logic [W_SY+W_FDRAW-1:0] my;

  assign mx = (W_SX+W_FDRAW)'(pix_i.src_x) * (W_SX+W_FDRAW)'(cfg_i.fdraw);
  assign my = (W_SY+W_FDRAW)'(pix_i.src_y) * (W_SY+W_FDRAW)'(cfg_i.fdraw);

  always_comb begin
    ent_o.pix   = pix_i.pixel_in;
    ent_o.lb    = blend_white(pix_i.pixel_in, 2'd3, 2'd2);
    ent_o.lc    = blend_white(pix_i.pixel_in, 2'd2, 2'd3);
    ent_o.bx    = cfg_i.off_x + mx[W_SX-1:0];
    ent_o.by    = cfg_i.off_y + my[W_SY-1:0];
    ent_o.fdraw = cfg_i.fdraw;
    ent_o.kind  = KIND_PLAIN;
    if (cfg_i.fdraw == W_FDRAW'(3)) begin
      if (cfg_i.look == LOOK_LCD) begin
        ent_o.kind = KIND_LCD;
      end else if (cfg_i.look == LOOK_DMG) begin
        ent_o.kind = KIND_DMG;
      end
    end
  end

endmodule

>>> design/ipu_queue.sv
// ----------------------------------------------------------------------------
// ipu_queue
// Short register queue between the classifying front and the block emitter.
// ----------------------------------------------------------------------------
module ipu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ipu_pkg::ent_t din_i,
  input  logic          pop_i,
  output ipu_pkg::ent_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import ipu_pkg::*;

  ent_t           mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QCW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + QAW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= din_i;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCW'(QDEPTH));

endmodule

>>> design/ipu_back.sv
// ----------------------------------------------------------------------------
// ipu_back
// Walks the block of the queue head and emits one screen pixel per cycle.
// ----------------------------------------------------------------------------
module ipu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ipu_pkg::ent_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          valid_o,
  output ipu_pkg::out_t res_o
);
  import ipu_pkg::*;

  logic [W_BLK-1:0] row_q, col_q;
  logic [W_BLK-1:0] fm1;
  logic             col_end, last;
  logic [W_PIX-1:0] pick;
  logic             valid_q;
  out_t             res_q;

  assign fm1     = W_BLK'(head_i.fdraw - W_FDRAW'(1));
  assign col_end = (col_q == fm1);
  assign last    = col_end && (row_q == fm1);
  assign pop_o   = !empty_i && last;

  always_comb begin
    unique case (head_i.kind)
      KIND_LCD: begin
        if (row_q == 2'd0) begin
          pick = (col_q == 2'd1) ? (head_i.pix & MASK_G) : PIX_BLACK;
        end else if (row_q == 2'd1) begin
          pick = (col_q == 2'd0) ? (head_i.pix & MASK_R) :
                 (col_q == 2'd1) ? (head_i.pix & MASK_G) : (head_i.pix & MASK_B);
        end else begin
          pick = (col_q == 2'd0) ? (head_i.pix & MASK_R) :
                 (col_q == 2'd1) ? PIX_BLACK : (head_i.pix & MASK_B);
        end
      end
      KIND_DMG: begin
        if (row_q < 2'd2) begin
          pick = (col_q == 2'd0) ? head_i.lb : head_i.pix;
        end else begin
          pick = (col_q == 2'd0) ? head_i.lc : head_i.lb;
        end
      end
      default: pick = head_i.pix;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        if (last) begin
          row_q <= '0;
          col_q <= '0;
        end else if (col_end) begin
          row_q <= row_q + W_BLK'(1);
          col_q <= '0;
        end else begin
          col_q <= col_q + W_BLK'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!empty_i) begin
      res_q.pixel_out  <= pick;
      res_q.dst_x      <= head_i.bx + W_SX'(col_q);
      res_q.dst_y      <= head_i.by + W_SY'(row_q);
      res_q.block_last <= last;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the integer pixel upscaler.
// Source pixels go in through the start/busy port, and the image size and
// look are set over APB. A predictor inside the bench computes every screen
// beat of each block (the table sets the first beat of some items), and each result beat is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import ipu_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 19;
  localparam int unsigned DRAIN_LIMIT     = 4000;

  localparam logic [1:0]        REG_UNUSED = 2'd3;
  localparam logic [W_LOOK-1:0] LOOK_PLAIN = W_LOOK'(0);
  localparam logic [W_LOOK-1:0] LOOK_SPARE = W_LOOK'(3);

  typedef enum logic {
    ROW_WRITE,
    ROW_PIXEL
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [1:0]         reg_sel;
    logic [APB_DW-1:0]  value;
    in_t                pixel;
    bit                 known;
    out_t               first_beat;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               pix_i = '0;
  logic              res_valid_o;
  out_t              res_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic [W_SX-1:0]   cfg_width = RST_SRC_WIDTH;
  logic [W_SY-1:0]   cfg_height = RST_SRC_HEIGHT;
  logic [W_LOOK-1:0] cfg_look = RST_LOOK_MODE;
  int                scale;
  int                off_x;
  int                off_y;

  out_t              expected_beats[$];
  stim_row_t         stimulus_table[$];
  out_t              beat_due;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;

  integer_pixel_upscaler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pix_i      (pix_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void rederive();
    int w;
    int h;
    int fx;
    int fy;
    w = (cfg_width == 0) ? 1 : int'(cfg_width);
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    fx = int'(SCREEN_W_DEF) / w;
    fy = int'(SCREEN_H_DEF) / h;
    scale = (fx < fy) ? fx : fy;
    off_x = (int'(SCREEN_W_DEF) - w * scale) / 2;
    off_y = (int'(SCREEN_H_DEF) - h * scale) / 2;
  endfunction

  function automatic logic [W_PIX-1:0] toward_white(logic [W_PIX-1:0] p, int wp, int ww);
    int r;
    int g;
    int b;
    r = (wp * int'(p[15:11]) + ww * 31) / 5;
    g = (wp * int'(p[10:5]) + ww * 63) / 5;
    b = (wp * int'(p[4:0]) + ww * 31) / 5;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic logic [W_PIX-1:0] screen_pixel(logic [W_PIX-1:0] s, int row, int col);
    if (scale != 3 || (cfg_look != LOOK_LCD && cfg_look != LOOK_DMG)) return s;
    if (cfg_look == LOOK_LCD) begin
      if (row == 0) return (col == 1) ? (s & MASK_G) : PIX_BLACK;
      if (row == 1) return (col == 0) ? (s & MASK_R) : ((col == 1) ? (s & MASK_G) : (s & MASK_B));
      return (col == 0) ? (s & MASK_R) : ((col == 1) ? PIX_BLACK : (s & MASK_B));
    end
    if (row < 2) return (col == 0) ? toward_white(s, 3, 2) : s;
    return (col == 0) ? toward_white(s, 2, 3) : toward_white(s, 3, 2);
  endfunction

  function automatic void predict_block(in_t it);
    int   f;
    int   bx;
    int   by;
    out_t b;
    f = (scale >= 2 && scale <= 4) ? scale : 1;
    bx = off_x + int'(it.src_x) * f;
    by = off_y + int'(it.src_y) * f;
    for (int row = 0; row < f; row++) begin
      for (int col = 0; col < f; col++) begin
        b.pixel_out = screen_pixel(it.pixel_in, row, col);
        b.dst_x = W_SX'(bx + col);
        b.dst_y = W_SY'(by + row);
        b.block_last = (row == f - 1 && col == f - 1);
        expected_beats.push_back(b);
      end
    end
  endfunction

  function automatic void report_mismatch(string what, out_t want, out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected pix %h x %0d y %0d last %b, got pix %h x %0d y %0d last %b",
               what, want.pixel_out, want.dst_x, want.dst_y, want.block_last,
               got.pixel_out, got.dst_x, got.dst_y, got.block_last);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0, res_o);
      end else begin
        beat_due = expected_beats.pop_front();
        if (res_o.pixel_out !== beat_due.pixel_out || res_o.dst_x !== beat_due.dst_x ||
            res_o.dst_y !== beat_due.dst_y || res_o.block_last !== beat_due.block_last) begin
          report_mismatch("beat mismatch", beat_due, res_o);
        end
      end
    end
  end

  function automatic void add_write(logic [1:0] sel, logic [APB_DW-1:0] value);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.reg_sel = sel;
    r.value = value;
    r.pixel = '0;
    r.known = 1'b0;
    r.first_beat = '0;
    stimulus_table.push_back(r);
  endfunction

  function automatic void add_known(logic [W_PIX-1:0] px, logic [W_SX-1:0] sx,
                                    logic [W_SY-1:0] sy, bit known, out_t first);
    stim_row_t r;
    r.kind = ROW_PIXEL;
    r.reg_sel = '0;
    r.value = '0;
    r.pixel = {px, sx, sy};
    r.known = known;
    r.first_beat = first;
    stimulus_table.push_back(r);
  endfunction

  function automatic void add_pixel(logic [W_PIX-1:0] px, logic [W_SX-1:0] sx,
                                    logic [W_SY-1:0] sy);
    add_known(px, sx, sy, 1'b0, '0);
  endfunction

  function automatic void build_table();
    add_known(16'hffff, 10'd0, 9'd0, 1'b1, {16'hffff, 10'd80, 9'd24, 1'b0});
    add_pixel(16'h0000, 10'd639, 9'd479);
    add_write(REG_LOOK_MODE, 32'(LOOK_LCD));
    add_known(16'hffff, 10'd1, 9'd1, 1'b1, {16'h0000, 10'd83, 9'd27, 1'b0});
    add_pixel(16'h1234, 10'd7, 9'd9);
    add_write(REG_LOOK_MODE, 32'(LOOK_DMG));
    add_known(16'hffff, 10'd0, 9'd0, 1'b1, {16'hffff, 10'd80, 9'd24, 1'b0});
    add_pixel(16'h0000, 10'd5, 9'd5);
    add_pixel(16'hf81f, 10'd159, 9'd143);
    add_write(REG_LOOK_MODE, 32'(LOOK_SPARE));
    add_pixel(16'habcd, 10'd2, 9'd3);
    add_write(REG_SRC_WIDTH, 32'd320);
    add_write(REG_SRC_HEIGHT, 32'd240);
    add_known(16'h07e0, 10'd0, 9'd0, 1'b1, {16'h07e0, 10'd0, 9'd0, 1'b0});
    add_pixel(16'h5a5a, 10'd319, 9'd239);
    add_write(REG_SRC_WIDTH, 32'd160);
    add_write(REG_SRC_HEIGHT, 32'd120);
    add_pixel(16'h001f, 10'd159, 9'd119);
    add_pixel(16'h8421, 10'd1023, 9'd511);
    add_write(REG_SRC_WIDTH, 32'd640);
    add_write(REG_SRC_HEIGHT, 32'd480);
    add_known(16'hffff, 10'd639, 9'd479, 1'b1, {16'hffff, 10'd639, 9'd479, 1'b1});
    add_write(REG_SRC_WIDTH, 32'd1023);
    add_write(REG_SRC_HEIGHT, 32'd511);
    add_known(16'h1234, 10'd0, 9'd0, 1'b1, {16'h1234, 10'd320, 9'd240, 1'b1});
    add_pixel(16'hc3c3, 10'd1023, 9'd511);
    add_write(REG_SRC_WIDTH, 32'd0);
    add_write(REG_SRC_HEIGHT, 32'd0);
    add_known(16'h5555, 10'd0, 9'd0, 1'b1, {16'h5555, 10'd80, 9'd0, 1'b1});
    add_write(REG_SRC_WIDTH, 32'd128);
    add_write(REG_SRC_HEIGHT, 32'd96);
    add_pixel(16'h3c3c, 10'd127, 9'd95);
    add_write(REG_SRC_WIDTH, 32'd100);
    add_write(REG_SRC_HEIGHT, 32'd100);
    add_write(REG_LOOK_MODE, 32'(LOOK_DMG));
    add_pixel(16'h7bef, 10'd99, 9'd99);
    add_write(REG_SRC_WIDTH, 32'd200);
    add_write(REG_SRC_HEIGHT, 32'd150);
    add_pixel(16'h0841, 10'd199, 9'd149);
    add_write(REG_LOOK_MODE, 32'(LOOK_LCD));
    add_pixel(16'hfedc, 10'd100, 9'd75);
    add_write(REG_UNUSED, 32'hffff_ffff);
    add_pixel(16'h2468, 10'd0, 9'd149);
    add_write(REG_LOOK_MODE, 32'(LOOK_PLAIN));
    add_pixel(16'h9bdf, 10'd33, 9'd44);
  endfunction

  task automatic write_register(logic [1:0] sel, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_SRC_WIDTH) cfg_width = value[W_SX-1:0];
    else if (sel == REG_SRC_HEIGHT) cfg_height = value[W_SY-1:0];
    else if (sel == REG_LOOK_MODE) cfg_look = value[W_LOOK-1:0];
    rederive();
    while (busy) @(negedge clk_i);
  endtask

  task automatic send_pixel(in_t it, int gap, bit known, out_t first);
    int base;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    pix_i <= it;
    do @(posedge clk_i); while (busy);
    base = expected_beats.size();
    predict_block(it);
    if (known) expected_beats[base] = first;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    if (start) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_beats.size() != 0) begin
      report_mismatch("missing beat", expected_beats[0], '0);
      mismatches += expected_beats.size() - 1;
      expected_beats.delete();
    end
  endtask

  initial begin
    in_t         it;
    int          f;
    int          w;
    int          h;
    int          category;
    bit          gapless;
    logic [3:0]  look;

    build_table();
    rederive();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stimulus_table[i]) begin
      if (stimulus_table[i].kind == ROW_WRITE) begin
        settle();
        write_register(stimulus_table[i].reg_sel, stimulus_table[i].value);
      end else begin
        send_pixel(stimulus_table[i].pixel, $urandom_range(0, 7),
                   stimulus_table[i].known, stimulus_table[i].first_beat);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      category = $urandom_range(0, 9);
      if (category <= 5) begin
        f = $urandom_range(2, 4);
        w = $urandom_range(int'(SCREEN_W_DEF) / (f + 1) + 1, int'(SCREEN_W_DEF) / f);
        h = $urandom_range(int'(SCREEN_H_DEF) / (f + 1) + 1, int'(SCREEN_H_DEF) / f);
      end else if (category <= 7) begin
        w = $urandom_range(0, 1023);
        h = $urandom_range(0, 511);
      end else if (category == 8) begin
        w = $urandom_range(0, 127);
        h = $urandom_range(0, 95);
      end else begin
        w = $urandom_range(0, 1) ? 1023 : 640;
        h = $urandom_range(0, 1) ? 511 : 480;
      end
      look = 4'($urandom_range(0, 3));
      settle();
      write_register(REG_SRC_WIDTH, w);
      write_register(REG_SRC_HEIGHT, h);
      write_register(REG_LOOK_MODE, {30'($urandom_range(0, 1 << 29)), look[1:0]});
      if (phase % 3 == 2) write_register(REG_UNUSED, $urandom);
      gapless = (phase % 3 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.pixel_in = W_PIX'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          it.src_x = W_SX'($urandom_range(0, 1023));
          it.src_y = W_SY'($urandom_range(0, 511));
        end else begin
          it.src_x = W_SX'($urandom_range(0, ((w > 0) ? w : 1) - 1));
          it.src_y = W_SY'($urandom_range(0, ((h > 0) ? h : 1) - 1));
        end
        send_pixel(it, gapless ? 0 : $urandom_range(0, 7), 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
design/ipu_pkg.sv
design/ipu_cfg.sv
design/ipu_front.sv
design/ipu_queue.sv
design/ipu_back.sv
design/integer_pixel_upscaler.sv
verif/tb.sv
